[hdl/page_framebuffer_text_render_defines.svh]
// Assertion helpers shared by the framebuffer text renderer.
`ifndef PAGE_FRAMEBUFFER_TEXT_RENDER_DEFINES_SVH
`define PAGE_FRAMEBUFFER_TEXT_RENDER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pfb_pkg.sv]
package pfb_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam int GLYPH_COLS  = 5;
    localparam int DRAW_STEPS  = 2 * GLYPH_COLS;
    localparam logic [7:0] CURSOR_STEP  = 8'd6;
    localparam logic [7:0] CURSOR_LIMIT = 8'd122;

    // Five glyph columns packed with column 0 in the top byte. Bit r of a
    // column is glyph row r. Codes without a glyph return all zeros.
    function automatic logic [39:0] font_bits(input logic [7:0] code);
        logic [39:0] f;
        case (code)
            8'h30: f = 40'h3E_51_49_45_3E;
            8'h31: f = 40'h00_42_7F_40_00;
            8'h32: f = 40'h42_61_51_49_46;
            8'h33: f = 40'h21_41_45_4B_31;
            8'h34: f = 40'h18_14_12_7F_10;
            8'h35: f = 40'h27_45_45_45_39;
            8'h36: f = 40'h3C_4A_49_49_30;
            8'h37: f = 40'h01_71_09_05_03;
            8'h38: f = 40'h36_49_49_49_36;
            8'h39: f = 40'h06_49_49_29_1E;
            8'h41: f = 40'h7E_11_11_11_7E;
            8'h43: f = 40'h3E_41_41_41_22;
            8'h45: f = 40'h7F_49_49_49_41;
            8'h48: f = 40'h7F_08_08_08_7F;
            8'h49: f = 40'h00_41_7F_41_00;
            8'h4D: f = 40'h7F_02_0C_02_7F;
            8'h4E: f = 40'h7F_04_08_10_7F;
            8'h4F: f = 40'h3E_41_41_41_3E;
            8'h50: f = 40'h7F_09_09_09_06;
            8'h52: f = 40'h7F_09_19_29_46;
            8'h53: f = 40'h46_49_49_49_31;
            8'h54: f = 40'h01_01_7F_01_01;
            8'h55: f = 40'h3F_40_40_40_3F;
            8'h56: f = 40'h1F_20_40_20_1F;
            8'h3A: f = 40'h00_36_36_00_00;
            8'h2E: f = 40'h00_60_60_00_00;
            8'h25: f = 40'h63_13_08_64_63;
            8'h2D: f = 40'h08_08_08_08_08;
            default: f = 40'h0;
        endcase
        return f;
    endfunction

endpackage

[hdl/pfb_ram.sv]
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/pfb_plot.sv]
module pfb_plot #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int ADDR_W        = 10
) (
    input  logic [7:0]        i_col,
    input  logic [7:0]        i_row,
    input  logic [7:0]        i_code,
    input  logic [3:0]        i_step,
    output logic              o_hit,
    output logic [ADDR_W-1:0] o_addr,
    output logic [7:0]        o_bits
);
    import pfb_pkg::*;

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam int FULL_PAGES = SCREEN_HEIGHT / 8;
    localparam logic [7:0] PART_MASK = 8'((16'd1 << (SCREEN_HEIGHT % 8)) - 16'd1);

    logic [2:0]  glyph_col;
    logic        half;
    logic [39:0] glyph;
    logic [7:0]  col_bits;
    logic [15:0] shifted;
    logic [7:0]  page_bits;
    logic [7:0]  x;
    logic [4:0]  page;
    logic [7:0]  row_mask;
    logic        x_ok;
    logic        page_ok;

    // Each step covers one glyph column and one of the two pages it spans.
    assign glyph_col = i_step[3:1];
    assign half      = i_step[0];
    assign glyph     = font_bits(i_code);
    assign col_bits  = glyph[8 * (4 - int'(glyph_col)) +: 8];
    assign shifted   = {9'd0, col_bits[6:0]} << i_row[2:0];
    assign page_bits = half ? shifted[15:8] : shifted[7:0];

    assign x    = i_col + {5'd0, glyph_col};
    assign page = i_row[7:3] + {4'd0, half};

    assign x_ok     = {1'b0, x} < 9'(SCREEN_WIDTH);
    assign page_ok  = int'(page) < PAGE_COUNT;
    assign row_mask = (int'(page) < FULL_PAGES) ? 8'hFF : PART_MASK;

    assign o_hit  = x_ok && page_ok;
    assign o_addr = ADDR_W'(int'(x) + int'(page) * SCREEN_WIDTH);
    assign o_bits = page_bits & row_mask;

endmodule

[hdl/page_framebuffer_text_render.sv]
// Throughput: one transaction at a time; a new start is taken in the cycle
// o_done shows. Draw time is set by ten read-modify-write steps on one RAM.
// Reset (synchronous, active low) zeroes the cursor and then sweeps the store to
// zero, one byte a cycle, with busy high; that sweep yields no result.
`include "page_framebuffer_text_render_defines.svh"

module page_framebuffer_text_render #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_start_x,
    input  logic [7:0] i_start_y,
    input  logic [7:0] i_glyph_code,
    input  logic       i_new_string,
    input  logic [9:0] i_read_address,
    output logic       o_done,
    output logic [7:0] o_read_byte,
    output logic       o_char_drawn
);
    import pfb_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int RA_W        = (ADDR_W > 10) ? ADDR_W : 10;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_DRAW  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;

    localparam logic [3:0]        LAST_STEP = 4'(DRAW_STEPS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    logic [2:0]        r_state;
    logic [ADDR_W-1:0] r_ptr;
    logic [3:0]        r_step;
    logic              r_report;
    logic [7:0]        r_cur_col;
    logic [7:0]        r_cur_row;
    logic              r_stopped;
    logic [7:0]        r_dcol;
    logic [7:0]        r_drow;
    logic [7:0]        r_code;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [7:0]        r_wr_bits;
    logic              r_rd_ok;
    logic              r_done;
    logic [7:0]        r_read_byte;
    logic              r_char_drawn;

    logic              accept;
    logic [7:0]        n_col;
    logic [7:0]        n_row;
    logic              n_stop;
    logic [7:0]        n_adv;
    logic [RA_W-1:0]   rd_wide;
    logic              plot_hit;
    logic [ADDR_W-1:0] plot_addr;
    logic [7:0]        plot_bits;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // A new string reloads the cursor and releases the stop flag before the
    // character itself is considered.
    assign n_col  = i_new_string ? i_start_x : r_cur_col;
    assign n_row  = i_new_string ? i_start_y : r_cur_row;
    assign n_stop = i_new_string ? 1'b0 : r_stopped;
    assign n_adv  = n_col + CURSOR_STEP;

    assign rd_wide = RA_W'(i_read_address);

    // Address and OR pattern of the current draw step.
    pfb_plot #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_plot (
        .i_col (r_dcol),
        .i_row (r_drow),
        .i_code(r_code),
        .i_step(r_step),
        .o_hit (plot_hit),
        .o_addr(plot_addr),
        .o_bits(plot_bits)
    );

    // The draw loop reads one byte per cycle and writes each byte back in
    // the cycle after its read. The ten bytes of a glyph are all distinct, so a read
    // never needs data still waiting to be written.
    assign mem_we    = (r_state == ST_CLEAR) || r_wr_pend;
    assign mem_waddr = (r_state == ST_CLEAR) ? r_ptr : r_wr_addr;
    assign mem_wdata = (r_state == ST_CLEAR) ? 8'h00 : (mem_rdata | r_wr_bits);
    assign mem_raddr = (r_state == ST_IDLE) ? rd_wide[ADDR_W-1:0] : plot_addr;

    pfb_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_frame (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_ptr     <= '0;
            r_step    <= '0;
            r_report  <= 1'b0;
            r_cur_col <= 8'd0;
            r_cur_row <= 8'd0;
            r_stopped <= 1'b0;
            r_wr_pend <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done    <= 1'b0;
            r_wr_pend <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_operation)
                            OP_CLEAR: begin
                                r_state  <= ST_CLEAR;
                                r_ptr    <= '0;
                                r_report <= 1'b1;
                            end
                            OP_DRAW: begin
                                r_cur_row <= n_row;
                                if (n_stop) begin
                                    // The string has run off the line.
                                    r_cur_col    <= n_col;
                                    r_stopped    <= 1'b1;
                                    r_done       <= 1'b1;
                                    r_read_byte  <= 8'd0;
                                    r_char_drawn <= 1'b0;
                                end else begin
                                    r_dcol    <= n_col;
                                    r_drow    <= n_row;
                                    r_code    <= i_glyph_code;
                                    r_cur_col <= n_adv;
                                    r_stopped <= (n_adv > CURSOR_LIMIT);
                                    r_step    <= '0;
                                    r_state   <= ST_DRAW;
                                end
                            end
                            OP_READ: begin
                                r_rd_ok <= (int'(i_read_address) < STORE_BYTES);
                                r_state <= ST_READ;
                            end
                            default: begin
                                r_done       <= 1'b1;
                                r_read_byte  <= 8'd0;
                                r_char_drawn <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_CLEAR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == LAST_ADDR) begin
                        r_state      <= ST_IDLE;
                        r_done       <= r_report;
                        r_report     <= 1'b0;
                        r_read_byte  <= 8'd0;
                        r_char_drawn <= 1'b0;
                    end
                end
                ST_DRAW: begin
                    r_wr_pend <= plot_hit;
                    r_wr_addr <= plot_addr;
                    r_wr_bits <= plot_bits;
                    r_step    <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    // The last write-back lands at the end of this cycle.
                    r_state      <= ST_IDLE;
                    r_done       <= 1'b1;
                    r_read_byte  <= 8'd0;
                    r_char_drawn <= 1'b1;
                end
                ST_READ: begin
                    r_state      <= ST_IDLE;
                    r_done       <= 1'b1;
                    r_read_byte  <= r_rd_ok ? mem_rdata : 8'd0;
                    r_char_drawn <= 1'b0;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_read_byte  = r_read_byte;
    assign o_char_drawn = r_char_drawn;

    `PFB_ASSERT_NOW(a_no_rmw_in_clear, i_clk, i_rst_n, (r_state == ST_CLEAR), !r_wr_pend, "write-back pending during clear")
    `PFB_ASSERT_NOW(a_step_range, i_clk, i_rst_n, (r_state == ST_DRAW), (r_step <= LAST_STEP), "draw step out of range")
    `PFB_ASSERT_NEXT(a_flush_done, i_clk, i_rst_n, (r_state == ST_FLUSH), (o_done && o_char_drawn), "draw finished without result")
    `PFB_ASSERT_NOW(a_result_excl, i_clk, i_rst_n, o_done, !(o_char_drawn && (o_read_byte != 8'd0)), "draw result carries read data")

endmodule
